// ===== design/kmeans_2d_clustering_assert.svh =====
// Assertion macros for the k-means clustering block.
// Used by the checker module; no other dependencies.
`ifndef KMEANS_2D_CLUSTERING_ASSERT_SVH
`define KMEANS_2D_CLUSTERING_ASSERT_SVH

// Condition implies consequence in the same cycle.
`define KMC_ASSERT_NOW(label, clk, rst, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error("kmc assertion failed");

// Condition implies consequence in the next cycle.
`define KMC_ASSERT_NEXT(label, clk, rst, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error("kmc assertion failed");

`endif

// ===== design/kmc_pkg.sv =====
// Shared types, constants and helpers for the k-means clustering block.
// No dependencies; imported by the top level, the divider and the testbench.
`timescale 1ns / 1ps
`default_nettype none

package kmc_pkg;

  localparam int MAX_POINTS   = 1024;
  localparam int PT_AW        = $clog2(MAX_POINTS);
  localparam int PT_CW        = PT_AW + 1;
  localparam int MAX_CLUSTERS = 16;
  localparam int CL_AW        = $clog2(MAX_CLUSTERS);
  localparam int MAX_RESTARTS = 16;
  localparam int RS_AW        = $clog2(MAX_RESTARTS);
  localparam int COORD_BITS   = 12;
  localparam int FRAC_BITS    = 8;
  localparam int SEED_DEPTH   = 256;
  localparam int SEED_AW      = $clog2(SEED_DEPTH);
  localparam int SEED_W       = 16;
  localparam int MEAN_W       = COORD_BITS + FRAC_BITS;
  localparam int SUM_W        = COORD_BITS + PT_AW;
  localparam int PROD_W       = 2 * MEAN_W;
  localparam int DIST_W       = PROD_W + 1;
  localparam int DSUM_W       = DIST_W + PT_AW;
  localparam int SCORE_W      = 48;
  localparam int THR_W        = 28;
  localparam int LBL_W        = 4;
  localparam int DATA_W       = 56;
  localparam int CFG_W        = 28;
  localparam int CFG_AW       = 2;

  // shared divider
  localparam int DIV_NW = DSUM_W;
  localparam int DIV_DW = PT_CW;
  localparam int DIV_CW = $clog2(DIV_NW + 1);

  // register indexes
  localparam logic [CFG_AW-1:0] CFG_CLUSTERS  = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_RESTARTS  = 2'd1;
  localparam logic [CFG_AW-1:0] CFG_ITER_LIM  = 2'd2;
  localparam logic [CFG_AW-1:0] CFG_THRESHOLD = 2'd3;

  // register reset values
  localparam logic [4:0]       RST_CLUSTERS  = 5'd2;
  localparam logic [4:0]       RST_RESTARTS  = 5'd10;
  localparam logic [7:0]       RST_ITER_LIM  = 8'd100;
  localparam logic [THR_W-1:0] RST_THRESHOLD = 28'd94372;

  // item kinds
  localparam logic [1:0] MODE_POINT = 2'd0;
  localparam logic [1:0] MODE_SEED  = 2'd1;
  localparam logic [1:0] MODE_RUN   = 2'd2;
  localparam logic [1:0] MODE_READ  = 2'd3;

  typedef enum logic [4:0] {
    S_IDLE, S_READ, S_FIN, S_START,
    S_SEED_RD, S_SEED_DIV, S_SEED_PT, S_SEED_WR,
    S_ASN_INIT, S_ASN_RD, S_ASN_J0, S_ASN_J1, S_ASN_J2, S_ASN_NEXT, S_ASN_WR,
    S_UPD_A, S_UPD_X, S_UPD_Y, S_UPD_D, S_UPD_E, S_UPD_F, S_UPD_NEXT,
    S_SCORE_A, S_SCORE_B, S_DECIDE
  } state_t;

  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] dividend;
    logic [DIV_DW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_NW-1:0] quotient;
    logic [DIV_DW-1:0] remainder;
  } div_rsp_t;

  function automatic logic [MEAN_W-1:0] absdiff(input logic [MEAN_W-1:0] a,
                                                input logic [MEAN_W-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

`default_nettype wire

// ===== design/kmeans_2d_clustering.sv =====
// Top level of the 2-D k-means clustering block (Lloyd iteration, restarts).
// Depends on kmc_pkg and kmc_div.
//
// Usage:
//   Slave stream: s_tuser is the item kind (load point, load seed, run, read
//   label); s_tdata carries the coordinates, seed word and point index.
//   Master stream: m_tdata carries label and best score, m_tuser score_valid.
//   Load items are taken back to back while the sequencer is idle and give no
//   transaction on the master side. A label read passes through S_READ and S_FIN before m_tvalid rises.
//   A run is worked by one sequencer around one 20x20 multiplier and one
//   51-step shift divider. Per restart: seeding of each cluster, then per
//   iteration an assignment pass over all points plus a mean update per
//   cluster; the final pass adds an assignment pass and scoring per cluster.
//   s_tready is low while a run or read is in progress.
//   The result sits in an output register; a stalled receiver holds it while
//   new load items are taken, and the next result waits until it drains.
//   Reset is synchronous: counts, label bank state and registers return to
//   their defaults at once, with no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module kmeans_2d_clustering (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  // x_coord[11:0], y_coord[23:12], seed_word[39:24], point_index[49:40]
  input  logic [kmc_pkg::DATA_W-1:0]  s_tdata,
  // mode[1:0]
  input  logic [1:0]                  s_tuser,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // label[3:0], best_score[51:4]
  output logic [kmc_pkg::DATA_W-1:0]  m_tdata,
  // score_valid[0]
  output logic [0:0]                  m_tuser,
  input  logic                        cfg_wen,
  input  logic [kmc_pkg::CFG_AW-1:0]  cfg_index,
  input  logic [kmc_pkg::CFG_W-1:0]   cfg_data
);
  import kmc_pkg::*;

  // configuration
  logic [4:0]       cluster_count;
  logic [4:0]       restart_count;
  logic [7:0]       iteration_limit;
  logic [THR_W-1:0] move_thr;

  state_t state, state_next;

  // stores
  logic [COORD_BITS-1:0] pt_x_mem [MAX_POINTS];
  logic [COORD_BITS-1:0] pt_y_mem [MAX_POINTS];
  logic [SEED_W-1:0]     seed_mem [SEED_DEPTH];
  logic [LBL_W-1:0]      lbl_mem  [2*MAX_POINTS];
  logic [COORD_BITS-1:0] pt_x_rd, pt_y_rd;
  logic [SEED_W-1:0]     seed_rd;
  logic [LBL_W-1:0]      lbl_rd;
  logic [PT_CW-1:0]      point_total;
  logic [SEED_AW:0]      seed_total;

  // cluster registers
  logic [MEAN_W-1:0] mean_x [MAX_CLUSTERS];
  logic [MEAN_W-1:0] mean_y [MAX_CLUSTERS];
  logic              mean_valid [MAX_CLUSTERS];
  logic [SUM_W-1:0]  sum_x [MAX_CLUSTERS];
  logic [SUM_W-1:0]  sum_y [MAX_CLUSTERS];
  logic [PT_CW-1:0]  member_count [MAX_CLUSTERS];
  logic [DSUM_W-1:0] dsum [MAX_CLUSTERS];

  // sequencer registers
  logic               best_bank, best_ok;
  logic [PT_CW-1:0]   best_total;
  logic [SCORE_W-1:0] lowest_score, score;
  logic [RS_AW-1:0]   r;
  logic [7:0]         iter;
  logic [SEED_AW-1:0] seed_idx;
  logic [CL_AW-1:0]   j, best_c;
  logic [PT_AW-1:0]   p, rd_idx;
  logic               final_pass, settled, reject, have_c;
  logic [DIST_W-1:0]  bd, acc;
  logic [MEAN_W-1:0]  nx, ny;
  logic [PROD_W-1:0]  prod;
  logic [LBL_W-1:0]   res_label;
  logic [SCORE_W-1:0] res_score;
  logic               res_valid;

  // control outputs
  logic              pt_ren, seed_ren, lbl_we, lbl_ren;
  logic [PT_AW-1:0]  pt_raddr;
  logic [MEAN_W-1:0] mul_a;
  div_req_t          div_req;
  div_rsp_t          div_rsp;

  // decode and derived values
  logic [1:0]            mode;
  logic [COORD_BITS-1:0] in_x, in_y;
  logic [SEED_W-1:0]     in_seed;
  logic [PT_AW-1:0]      in_idx;
  logic                  accept, out_free;
  logic [CL_AW-1:0]      k_last;
  logic [RS_AW-1:0]      runs_last;
  logic [7:0]            lim_eff;
  logic [8:0]            iter_inc;
  logic                  j_last, p_last, div_done;
  logic [DIST_W-1:0]     dist_sum;
  logic [SCORE_W+3:0]    score_sum;
  logic                  take_now;
  logic [MEAN_W-1:0]     px_q, py_q;

  assign mode     = s_tuser;
  assign in_x     = s_tdata[11:0];
  assign in_y     = s_tdata[23:12];
  assign in_seed  = s_tdata[39:24];
  assign in_idx   = s_tdata[49:40];
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign div_done = div_rsp.done;

  always_comb begin
    if (cluster_count > 5'(MAX_CLUSTERS)) k_last = CL_AW'(MAX_CLUSTERS - 1);
    else k_last = CL_AW'(cluster_count - 5'd1);
    if (restart_count == 5'd0) runs_last = '0;
    else if (restart_count > 5'(MAX_RESTARTS)) runs_last = RS_AW'(MAX_RESTARTS - 1);
    else runs_last = RS_AW'(restart_count - 5'd1);
    lim_eff = (iteration_limit == 8'd0) ? 8'd1 : iteration_limit;
  end

  assign iter_inc  = {1'b0, iter} + 9'd1;
  assign j_last    = (j == k_last);
  assign p_last    = ({1'b0, p} == point_total - PT_CW'(1));
  assign dist_sum  = acc + {1'b0, prod};
  assign score_sum = (SCORE_W+4)'(score) + (SCORE_W+4)'(div_rsp.quotient);
  assign take_now  = !reject && (score < lowest_score);
  assign px_q      = {pt_x_rd, {FRAC_BITS{1'b0}}};
  assign py_q      = {pt_y_rd, {FRAC_BITS{1'b0}}};

  kmc_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // shared multiplier, registered product
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_a;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (mode)
            MODE_RUN: begin
              if (point_total == '0 || cluster_count <= 5'd1) state_next = S_FIN;
              else state_next = S_START;
            end
            MODE_READ: state_next = S_READ;
            default:   state_next = S_IDLE;
          endcase
        end
      end
      S_READ:     state_next = S_FIN;
      S_FIN:      if (out_free) state_next = S_IDLE;
      S_START:    state_next = S_SEED_RD;
      S_SEED_RD:  state_next = S_SEED_DIV;
      S_SEED_DIV: state_next = S_SEED_PT;
      S_SEED_PT:  if (div_done) state_next = S_SEED_WR;
      S_SEED_WR:  state_next = j_last ? S_ASN_INIT : S_SEED_RD;
      S_ASN_INIT: state_next = S_ASN_RD;
      S_ASN_RD:   state_next = S_ASN_J0;
      S_ASN_J0:   state_next = mean_valid[j] ? S_ASN_J1 : S_ASN_NEXT;
      S_ASN_J1:   state_next = S_ASN_J2;
      S_ASN_J2:   state_next = S_ASN_NEXT;
      S_ASN_NEXT: state_next = j_last ? S_ASN_WR : S_ASN_J0;
      S_ASN_WR: begin
        if (!p_last) state_next = S_ASN_RD;
        else state_next = final_pass ? S_SCORE_A : S_UPD_A;
      end
      S_UPD_A: begin
        if (!mean_valid[j] || member_count[j] == '0) state_next = S_UPD_NEXT;
        else state_next = S_UPD_X;
      end
      S_UPD_X:    if (div_done) state_next = S_UPD_Y;
      S_UPD_Y:    if (div_done) state_next = S_UPD_D;
      S_UPD_D:    state_next = S_UPD_E;
      S_UPD_E:    state_next = S_UPD_F;
      S_UPD_F:    state_next = S_UPD_NEXT;
      S_UPD_NEXT: state_next = j_last ? S_ASN_INIT : S_UPD_A;
      S_SCORE_A:  state_next = (member_count[j] == '0) ? S_DECIDE : S_SCORE_B;
      S_SCORE_B:  if (div_done) state_next = j_last ? S_DECIDE : S_SCORE_A;
      S_DECIDE:   state_next = (r == runs_last) ? S_FIN : S_START;
      default:    state_next = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    s_tready         = 1'b0;
    pt_ren           = 1'b0;
    pt_raddr         = p;
    seed_ren         = 1'b0;
    lbl_we           = 1'b0;
    lbl_ren          = 1'b0;
    mul_a            = '0;
    div_req.start    = 1'b0;
    div_req.dividend = '0;
    div_req.divisor  = member_count[j];
    unique case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        lbl_ren  = accept && (mode == MODE_READ);
      end
      S_SEED_RD: seed_ren = 1'b1;
      S_SEED_DIV: begin
        div_req.start    = 1'b1;
        div_req.dividend = ({1'b0, seed_idx} < seed_total) ? DIV_NW'(seed_rd) : '0;
        div_req.divisor  = point_total;
      end
      S_SEED_PT: begin
        pt_ren   = div_done;
        pt_raddr = div_rsp.remainder[PT_AW-1:0];
      end
      S_ASN_RD: pt_ren = 1'b1;
      S_ASN_J0: mul_a = absdiff(px_q, mean_x[j]);
      S_ASN_J1: mul_a = absdiff(py_q, mean_y[j]);
      S_ASN_WR: lbl_we = 1'b1;
      S_UPD_A: begin
        div_req.start    = mean_valid[j] && (member_count[j] != '0);
        div_req.dividend = DIV_NW'({sum_x[j], {FRAC_BITS{1'b0}}});
      end
      S_UPD_X: begin
        div_req.start    = div_done;
        div_req.dividend = DIV_NW'({sum_y[j], {FRAC_BITS{1'b0}}});
      end
      S_UPD_D: mul_a = absdiff(nx, mean_x[j]);
      S_UPD_E: mul_a = absdiff(ny, mean_y[j]);
      S_SCORE_A: begin
        div_req.start    = (member_count[j] != '0);
        div_req.dividend = dsum[j];
      end
      default: ;
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cluster_count   <= RST_CLUSTERS;
      restart_count   <= RST_RESTARTS;
      iteration_limit <= RST_ITER_LIM;
      move_thr        <= RST_THRESHOLD;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        CFG_CLUSTERS:  cluster_count   <= cfg_data[4:0];
        CFG_RESTARTS:  restart_count   <= cfg_data[4:0];
        CFG_ITER_LIM:  iteration_limit <= cfg_data[7:0];
        CFG_THRESHOLD: move_thr        <= cfg_data;
        default: ;
      endcase
    end
  end

  // point, seed and label memories
  always_ff @(posedge clk) begin
    if (state == S_IDLE && accept && mode == MODE_POINT && point_total < PT_CW'(MAX_POINTS)) begin
      pt_x_mem[point_total[PT_AW-1:0]] <= in_x;
      pt_y_mem[point_total[PT_AW-1:0]] <= in_y;
    end
    if (pt_ren) begin
      pt_x_rd <= pt_x_mem[pt_raddr];
      pt_y_rd <= pt_y_mem[pt_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && accept && mode == MODE_SEED && seed_total < (SEED_AW+1)'(SEED_DEPTH))
      seed_mem[seed_total[SEED_AW-1:0]] <= in_seed;
    if (seed_ren) seed_rd <= seed_mem[seed_idx];
  end

  // two label banks: the working one is the bank not marked best
  always_ff @(posedge clk) begin
    if (lbl_we) lbl_mem[{~best_bank, p}] <= best_c;
    if (lbl_ren) lbl_rd <= lbl_mem[{best_bank, in_idx}];
  end

  // sequencer control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      point_total  <= '0;
      seed_total   <= '0;
      best_bank    <= 1'b0;
      best_ok      <= 1'b0;
      best_total   <= '0;
      lowest_score <= '1;
      m_tvalid     <= 1'b0;
    end else begin
      state <= state_next;
      // result offered from S_FIN, withdrawn once taken
      if (state == S_FIN && out_free) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (mode)
              MODE_POINT: if (point_total < PT_CW'(MAX_POINTS)) point_total <= point_total + 1'b1;
              MODE_SEED: begin
                if (seed_total < (SEED_AW+1)'(SEED_DEPTH)) seed_total <= seed_total + 1'b1;
              end
              MODE_RUN: begin
                best_ok      <= 1'b0;
                best_total   <= point_total;
                lowest_score <= '1;
              end
              default: ;
            endcase
          end
        end
        S_DECIDE: begin
          if (take_now) begin
            lowest_score <= score;
            best_ok      <= 1'b1;
            best_bank    <= ~best_bank;
          end
        end
        default: ;
      endcase
    end
  end

  // sequencer datapath
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        r         <= '0;
        seed_idx  <= '0;
        rd_idx    <= in_idx;
        res_label <= '0;
        res_score <= '0;
        res_valid <= 1'b0;
      end
      S_READ: begin
        res_label <= (best_ok && {1'b0, rd_idx} < best_total) ? lbl_rd : '0;
      end
      S_FIN: begin
        if (out_free) begin
          m_tdata <= DATA_W'({res_score, res_label});
          m_tuser <= res_valid;
        end
      end
      S_START: begin
        j    <= '0;
        iter <= '0;
      end
      S_SEED_WR: begin
        mean_x[j]     <= px_q;
        mean_y[j]     <= py_q;
        mean_valid[j] <= 1'b1;
        seed_idx      <= seed_idx + 1'b1;
        j             <= j_last ? '0 : j + 1'b1;
        final_pass    <= 1'b0;
      end
      S_ASN_INIT: begin
        for (int c = 0; c < MAX_CLUSTERS; c++) begin
          sum_x[c]        <= '0;
          sum_y[c]        <= '0;
          member_count[c] <= '0;
          dsum[c]         <= '0;
        end
        p <= '0;
      end
      S_ASN_RD: begin
        j      <= '0;
        have_c <= 1'b0;
        best_c <= '0;
        bd     <= '0;
      end
      S_ASN_J1: acc <= DIST_W'(prod);
      S_ASN_J2: begin
        if (!have_c || dist_sum < bd) begin
          bd     <= dist_sum;
          best_c <= j;
          have_c <= 1'b1;
        end
      end
      S_ASN_NEXT: if (!j_last) j <= j + 1'b1;
      S_ASN_WR: begin
        sum_x[best_c]        <= sum_x[best_c] + SUM_W'(pt_x_rd);
        sum_y[best_c]        <= sum_y[best_c] + SUM_W'(pt_y_rd);
        member_count[best_c] <= member_count[best_c] + 1'b1;
        if (final_pass) dsum[best_c] <= dsum[best_c] + DSUM_W'(bd);
        p       <= p + 1'b1;
        j       <= '0;
        settled <= 1'b1;
        score   <= '0;
        reject  <= 1'b0;
      end
      S_UPD_A: begin
        if (!mean_valid[j] || member_count[j] == '0) mean_valid[j] <= 1'b0;
      end
      S_UPD_X: if (div_done) nx <= div_rsp.quotient[MEAN_W-1:0];
      S_UPD_Y: if (div_done) ny <= div_rsp.quotient[MEAN_W-1:0];
      S_UPD_E: acc <= DIST_W'(prod);
      S_UPD_F: begin
        if (dist_sum > DIST_W'(move_thr)) settled <= 1'b0;
        mean_x[j] <= nx;
        mean_y[j] <= ny;
      end
      S_UPD_NEXT: begin
        if (j_last) begin
          j          <= '0;
          iter       <= iter_inc[7:0];
          final_pass <= settled || (iter_inc >= {1'b0, lim_eff});
        end else begin
          j <= j + 1'b1;
        end
      end
      S_SCORE_A: if (member_count[j] == '0) reject <= 1'b1;
      S_SCORE_B: begin
        if (div_done) begin
          score <= (score_sum > (SCORE_W+4)'({SCORE_W{1'b1}})) ? '1 : score_sum[SCORE_W-1:0];
          if (!j_last) j <= j + 1'b1;
        end
      end
      S_DECIDE: begin
        r         <= r + 1'b1;
        res_label <= '0;
        res_valid <= best_ok || take_now;
        res_score <= take_now ? score : (best_ok ? lowest_score : '0);
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ===== design/kmc_div.sv =====
// Shared restoring divider: one quotient bit per cycle, quotient and remainder.
// Depends on kmc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module kmc_div (
  input  logic             clk,
  input  logic             rst,
  input  kmc_pkg::div_req_t req,
  output kmc_pkg::div_rsp_t rsp
);
  import kmc_pkg::*;

  logic              busy;
  logic              done;
  logic [DIV_CW-1:0] cnt;
  logic [DIV_NW-1:0] quo;
  logic [DIV_DW-1:0] rem;
  logic [DIV_DW-1:0] dsor;
  logic [DIV_DW:0]   trial;
  logic              fit;

  // trial subtract of the next partial remainder
  assign trial = {rem, quo[DIV_NW-1]};
  assign fit   = trial >= {1'b0, dsor};

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= DIV_CW'(DIV_NW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == DIV_CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      quo  <= req.dividend;
      rem  <= '0;
      dsor <= req.divisor;
    end else if (busy) begin
      quo <= {quo[DIV_NW-2:0], fit};
      rem <= fit ? DIV_DW'(trial - {1'b0, dsor}) : trial[DIV_DW-1:0];
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = quo;
  assign rsp.remainder = rem;

endmodule

`default_nettype wire

// ===== design/kmc_checker.sv =====
// Port-level checker for the k-means clustering block, bound to the top level.
// Depends on kmeans_2d_clustering_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "kmeans_2d_clustering_assert.svh"

module kmc_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [1:0]  s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [55:0] m_tdata,
  input logic [0:0]  m_tuser
);

  // a stalled result stays offered
  `KMC_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid)

  // runs and label reads occupy the sequencer
  `KMC_ASSERT_NEXT(a_busy_after_cmd, clk, rst, s_tvalid && s_tready && s_tuser[1], !s_tready)

  // load items raise no result
  `KMC_ASSERT_NEXT(a_load_silent, clk, rst,
                   s_tvalid && s_tready && !s_tuser[1] && !m_tvalid, !m_tvalid)

  // a nonzero label comes from a read, which carries no score
  `KMC_ASSERT_NOW(a_read_no_score, clk, rst, m_tvalid && m_tdata[3:0] != 4'd0,
                  m_tdata[51:4] == 48'd0 && !m_tuser[0])

endmodule

bind kmeans_2d_clustering kmc_checker u_kmc_checker (.*);

`default_nettype wire

// ===== tb/tb_kmeans_2d_clustering.sv =====
// Self-checking testbench for the 2-D k-means clustering block.
// Depends on kmc_pkg and the kmeans_2d_clustering RTL; predicts every result in place.
`timescale 1ns / 1ps

module tb_kmeans_2d_clustering;
  import kmc_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000000;
  localparam longint unsigned SCORE_MAX = 64'hFFFF_FFFF_FFFF;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [DATA_W-1:0] s_tdata = '0;
  logic [1:0] s_tuser = MODE_POINT;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [DATA_W-1:0] m_tdata;
  logic [0:0] m_tuser;
  logic cfg_wen = 1'b0;
  logic [CFG_AW-1:0] cfg_index = CFG_CLUSTERS;
  logic [CFG_W-1:0] cfg_data = '0;

  // clock: 8 ns period
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  kmeans_2d_clustering u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  typedef struct {
    logic [3:0]  label;
    logic [47:0] score;
    logic        score_ok;
  } cluster_result_t;

  cluster_result_t result_q[$];

  // mirror of the block state
  logic [4:0]  k_reg;
  logic [4:0]  restarts_reg;
  logic [7:0]  iter_reg;
  logic [27:0] thresh_reg;
  logic [11:0] px[MAX_POINTS];
  logic [11:0] py[MAX_POINTS];
  int          n_pts;
  logic [15:0] seeds[SEED_DEPTH];
  int          n_seeds;
  logic [3:0]  best_lbl[MAX_POINTS];
  logic [3:0]  cur_lbl[MAX_POINTS];
  longint unsigned mx[MAX_CLUSTERS];
  longint unsigned my[MAX_CLUSTERS];
  bit          mvalid[MAX_CLUSTERS];
  longint unsigned sx[MAX_CLUSTERS];
  longint unsigned sy[MAX_CLUSTERS];
  int          members[MAX_CLUSTERS];
  longint unsigned lowest;

  int mismatches = 0;
  int n_results = 0;
  int n_runs = 0;
  int n_reads = 0;
  int n_items = 0;
  int idle_cycles = 0;

  function automatic longint unsigned sq_diff(longint unsigned a, longint unsigned b);
    longint unsigned d;
    d = (a > b) ? a - b : b - a;
    return d * d;
  endfunction

  function automatic longint unsigned pt_dist(int p, int c);
    return sq_diff(longint'(px[p]) << FRAC_BITS, mx[c]) +
           sq_diff(longint'(py[p]) << FRAC_BITS, my[c]);
  endfunction

  // nearest valid mean, lowest index wins ties
  function automatic int closest_mean(int p, int k);
    int best;
    longint unsigned bd;
    bit found;
    longint unsigned d;
    best = 0; bd = 0; found = 0;
    for (int j = 0; j < k; j++) begin
      if (mvalid[j]) begin
        d = pt_dist(p, j);
        if (!found || d < bd) begin
          bd = d; best = j; found = 1;
        end
      end
    end
    return best;
  endfunction

  function automatic void assign_points(int k);
    int c;
    for (int j = 0; j < k; j++) begin
      sx[j] = 0; sy[j] = 0; members[j] = 0;
    end
    for (int p = 0; p < n_pts; p++) begin
      c = closest_mean(p, k);
      cur_lbl[p] = c[3:0];
      sx[c] += px[p];
      sy[c] += py[p];
      members[c]++;
    end
  endfunction

  // all restarts of one run; returns 1 if some restart was kept
  function automatic bit lloyd_restarts();
    int k, runs, lim, iter, si, c;
    longint unsigned w, pi, nx, ny, score;
    longint unsigned dsum[MAX_CLUSTERS];
    bit settled, reject, found;
    k = (k_reg > MAX_CLUSTERS) ? MAX_CLUSTERS : int'(k_reg);
    runs = (restarts_reg == 0) ? 1 : int'(restarts_reg);
    if (runs > MAX_RESTARTS) runs = MAX_RESTARTS;
    lim = (iter_reg == 0) ? 1 : int'(iter_reg);
    found = 0;
    for (int r = 0; r < runs; r++) begin
      for (int j = 0; j < k; j++) begin
        si = (r * k + j) % SEED_DEPTH;
        w = (si < n_seeds) ? seeds[si] : 0;
        pi = w % n_pts;
        mx[j] = longint'(px[pi]) << FRAC_BITS;
        my[j] = longint'(py[pi]) << FRAC_BITS;
        mvalid[j] = 1;
      end
      iter = 0;
      do begin
        assign_points(k);
        settled = 1;
        for (int j = 0; j < k; j++) begin
          if (!mvalid[j] || members[j] == 0) begin
            mvalid[j] = 0;
          end else begin
            nx = (sx[j] << FRAC_BITS) / members[j];
            ny = (sy[j] << FRAC_BITS) / members[j];
            if (sq_diff(nx, mx[j]) + sq_diff(ny, my[j]) > thresh_reg) settled = 0;
            mx[j] = nx;
            my[j] = ny;
          end
        end
        iter++;
      end while (!settled && iter < lim);
      // final assignment and score
      assign_points(k);
      for (int j = 0; j < k; j++) dsum[j] = 0;
      for (int p = 0; p < n_pts; p++) begin
        c = cur_lbl[p];
        dsum[c] += pt_dist(p, c);
      end
      score = 0;
      reject = 0;
      for (int j = 0; j < k; j++) begin
        if (members[j] == 0) begin
          reject = 1;
          break;
        end
        score += dsum[j] / members[j];
        if (score > SCORE_MAX) score = SCORE_MAX;
      end
      if (!reject && score < lowest) begin
        lowest = score;
        found = 1;
        for (int p = 0; p < n_pts; p++) best_lbl[p] = cur_lbl[p];
      end
    end
    return found;
  endfunction

  // update mirror for one accepted item and queue its result
  function automatic void predict_item(logic [1:0] mode, logic [11:0] x, logic [11:0] y,
                                       logic [15:0] sw, logic [9:0] idx);
    cluster_result_t res;
    bit ok;
    case (mode)
      MODE_POINT: begin
        if (n_pts < MAX_POINTS) begin
          px[n_pts] = x; py[n_pts] = y; n_pts++;
        end
      end
      MODE_SEED: begin
        if (n_seeds < SEED_DEPTH) begin
          seeds[n_seeds] = sw; n_seeds++;
        end
      end
      MODE_RUN: begin
        for (int p = 0; p < MAX_POINTS; p++) best_lbl[p] = '0;
        lowest = SCORE_MAX;
        ok = 0;
        if (n_pts > 0 && k_reg > 1) ok = lloyd_restarts();
        res.label = '0;
        res.score = ok ? lowest[47:0] : '0;
        res.score_ok = ok;
        result_q = {result_q, res};
        n_runs++;
      end
      default: begin
        res.label = best_lbl[idx];
        res.score = '0;
        res.score_ok = 1'b0;
        result_q = {result_q, res};
        n_reads++;
      end
    endcase
  endfunction

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_item(logic [1:0] mode, logic [11:0] x, logic [11:0] y,
                           logic [15:0] sw, logic [9:0] idx);
    int gap;
    s_tvalid <= 1'b1;
    s_tuser <= mode;
    s_tdata <= {6'b0, idx, sw, y, x};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_item(mode, x, y, sw, idx);
    n_items++;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_random(logic [1:0] mode);
    send_item(mode, 12'($urandom), 12'($urandom), 16'($urandom), 10'($urandom));
  endtask

  task automatic send_read(int idx);
    send_item(MODE_READ, 12'($urandom), 12'($urandom), 16'($urandom), idx[9:0]);
  endtask

  // hold off until every expected result has drained and the block is quiet
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (result_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // one register write; the caller drops the enable after the last one
  task automatic write_reg(logic [CFG_AW-1:0] idx, logic [CFG_W-1:0] val);
    cfg_wen <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      CFG_CLUSTERS: k_reg = val[4:0];
      CFG_RESTARTS: restarts_reg = val[4:0];
      CFG_ITER_LIM: iter_reg = val[7:0];
      default:      thresh_reg = val[27:0];
    endcase
  endtask

  task automatic set_config(int k, int r, int it, logic [27:0] th);
    drain();
    write_reg(CFG_CLUSTERS, CFG_W'(k));
    write_reg(CFG_RESTARTS, CFG_W'(r));
    write_reg(CFG_ITER_LIM, CFG_W'(it));
    write_reg(CFG_THRESHOLD, CFG_W'(th));
    cfg_wen <= 1'b0;
  endtask

  // run on an empty point store, label reads before any run
  task automatic test_empty_store();
    send_read(0);
    send_read(1023);
    send_random(MODE_RUN);
  endtask

  // corner coordinates and seeds, then a run at reset settings and label reads
  task automatic test_small_set();
    send_item(MODE_POINT, 12'd0, 12'd0, 16'($urandom), 10'($urandom));
    send_item(MODE_POINT, 12'hFFF, 12'hFFF, 16'($urandom), 10'($urandom));
    send_item(MODE_POINT, 12'd0, 12'hFFF, 16'($urandom), 10'($urandom));
    send_item(MODE_POINT, 12'hFFF, 12'd0, 16'($urandom), 10'($urandom));
    repeat (4) send_random(MODE_POINT);
    send_item(MODE_SEED, 12'($urandom), 12'($urandom), 16'h0000, 10'($urandom));
    send_item(MODE_SEED, 12'($urandom), 12'($urandom), 16'hFFFF, 10'($urandom));
    repeat (3) send_random(MODE_SEED);
    send_random(MODE_RUN);
    for (int i = 0; i < 8; i++) send_read(i);
  endtask

  // register extremes: single cluster, saturated k and restarts, zero limits
  task automatic test_register_extremes();
    set_config(1, 1, 5, 28'd1000);
    send_random(MODE_RUN);
    send_read(1);
    set_config(0, 2, 5, 28'd1000);
    send_random(MODE_RUN);
    set_config(31, 31, 255, 28'd0);
    send_random(MODE_RUN);
    send_read(3);
    set_config(16, 16, 0, 28'hFFFFFFF);
    send_random(MODE_RUN);
    set_config(3, 0, 255, 28'd0);
    send_random(MODE_RUN);
    send_read(2);
    send_read(7);
  endtask

  // random loads and reads in phases, each ending in a run and label reads
  task automatic test_random_phases();
    int burst, r;
    logic [27:0] th;
    while (n_items < 250) begin
      r = $urandom_range(0, 3);
      th = (r == 0) ? 28'd0 : (r == 1) ? 28'hFFFFFFF : 28'($urandom_range(0, 200000));
      set_config($urandom_range(2, 6), $urandom_range(1, 3), $urandom_range(1, 6), th);
      burst = $urandom_range(15, 40);
      for (int i = 0; i < burst; i++) begin
        r = $urandom_range(0, 99);
        if (r < 50 && n_pts < 110) send_random(MODE_POINT);
        else if (r < 70) send_random(MODE_SEED);
        else if (r < 85) send_read($urandom_range(0, n_pts + 2));
        else if (r < 97) send_random(MODE_READ);
        else send_random(MODE_RUN);
      end
      send_random(MODE_RUN);
      repeat (4) send_read($urandom_range(0, n_pts - 1));
    end
  endtask

  // fill the seed store past capacity, then one short run on the full store and label reads
  task automatic test_store_full();
    for (int i = n_seeds; i < SEED_DEPTH + 4; i++) send_random(MODE_SEED);
    set_config(2, 1, 1, 28'hFFFFFFF);
    send_random(MODE_RUN);
    send_read(1023);
    send_read(512);
    send_random(MODE_READ);
  endtask

  // receiver stalls: random levels held for random stretches
  int rdy_left = 0;
  always @(posedge clk) begin
    if (rdy_left == 0) begin
      if ($urandom_range(0, 3) == 0) begin
        m_tready <= 1'b1;
        rdy_left <= $urandom_range(20, 60);
      end else if ($urandom_range(0, 9) == 0) begin
        m_tready <= 1'b0;
        rdy_left <= $urandom_range(10, 40);
      end else begin
        m_tready <= $urandom_range(0, 1);
        rdy_left <= $urandom_range(1, 3);
      end
    end else begin
      rdy_left <= rdy_left - 1;
    end
  end

  // result checker and watchdog
  always @(posedge clk) begin
    cluster_result_t want;
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
      if (m_tvalid && m_tready) begin
        n_results++;
        if (result_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result: tdata=%h", m_tdata);
        end else begin
          want = result_q.pop_front();
          if (m_tdata[3:0] !== want.label || m_tdata[51:4] !== want.score ||
              m_tuser[0] !== want.score_ok) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result %0d: exp label=%0d score=%0d valid=%0b, got %0d %0d %0b",
                       n_results, want.label, want.score, want.score_ok,
                       m_tdata[3:0], m_tdata[51:4], m_tuser[0]);
          end
        end
      end
    end
  end

  initial begin
    k_reg = RST_CLUSTERS;
    restarts_reg = RST_RESTARTS;
    iter_reg = RST_ITER_LIM;
    thresh_reg = RST_THRESHOLD;
    n_pts = 0;
    n_seeds = 0;
    lowest = SCORE_MAX;
    for (int p = 0; p < MAX_POINTS; p++) best_lbl[p] = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_store();
    test_small_set();
    test_register_extremes();
    test_random_phases();
    test_store_full();

    drain();
    $display("covered %0d items: %0d runs, %0d label reads, %0d points, %0d results",
             n_items, n_runs, n_reads, n_pts, n_results);
    if (mismatches == 0 && result_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, result_q.size());
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
